>>> rtl/vsync_frame_target_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef VSYNC_FRAME_TARGET_SCHEDULER_ASSERT_SVH
`define VSYNC_FRAME_TARGET_SCHEDULER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define VFTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define VFTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

>>> rtl/vsfts_pkg.sv
package vsfts_pkg;

    localparam int TIME_W   = 63;
    localparam int WIDE_W   = 64;
    localparam int CFG_W    = 30;
    localparam int CMD_W    = 1;
    localparam int IDX_W    = 1;
    localparam int DIV_STEPS = WIDE_W;
    localparam int CNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [CFG_W-1:0]  FRAME_INTERVAL_RESET = CFG_W'(16666667);
    localparam logic [CFG_W-1:0]  START_OFFSET_RESET   = '0;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] CFG_FRAME_INTERVAL = 1'b0;
    localparam logic [IDX_W-1:0] CFG_START_OFFSET   = 1'b1;

    // Request kinds.
    localparam logic [CMD_W-1:0] CMD_PRIMARY   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SECONDARY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SNAP,
        S_WAIT0,
        S_NEED1,
        S_WAIT1,
        S_NEED2,
        S_WAIT2,
        S_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        DIV_ELAPSED,
        DIV_NEED1,
        DIV_NEED2
    } div_src_t;

    typedef enum logic [1:0] {
        NEXT_PRED,
        NEXT_NOW_IVL,
        NEXT_SNAP
    } next_sel_t;

    typedef enum logic [1:0] {
        CAND_NEXT,
        CAND_UP1,
        CAND_MAX2
    } cand_sel_t;

    typedef struct packed {
        logic      load_in;
        logic      div_start;
        div_src_t  div_src;
        logic      next_load;
        next_sel_t next_sel;
        logic      cand_load;
        cand_sel_t cand_sel;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic pred_gt_now;
        logic last_gt_now;
        logic next_ge_need1;
        logic next_ge_need2;
        logic secondary;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/vsfts_div.sv
module vsfts_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [vsfts_pkg::WIDE_W-1:0]  dividend,
    input  logic [vsfts_pkg::CFG_W-1:0]   divisor,
    output logic                          busy,
    output logic [vsfts_pkg::CFG_W-1:0]   rem
);

    logic [vsfts_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [vsfts_pkg::WIDE_W-1:0] dvd_reg, dvd_next;
    logic [vsfts_pkg::CFG_W-1:0]  rem_reg, rem_next;
    logic [vsfts_pkg::CFG_W:0]    trial;
    logic [vsfts_pkg::CFG_W:0]    diff;

    assign busy = (cnt_reg != '0);
    assign rem  = rem_reg;

    // Restoring remainder: one dividend bit a cycle, MSB first.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[vsfts_pkg::WIDE_W-1]};
        diff     = trial - {1'b0, divisor};
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = vsfts_pkg::CNT_W'(vsfts_pkg::DIV_STEPS);
            dvd_next = dividend;
            rem_next = '0;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - vsfts_pkg::CNT_W'(1);
            dvd_next = {dvd_reg[vsfts_pkg::WIDE_W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, divisor}) ? diff[vsfts_pkg::CFG_W-1:0]
                                                  : trial[vsfts_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

endmodule

>>> rtl/vsfts_dp.sv
module vsfts_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [vsfts_pkg::IDX_W-1:0]         cfg_index,
    input  logic [vsfts_pkg::CFG_W-1:0]         cfg_data,
    input  logic [vsfts_pkg::CMD_W-1:0]         command,
    input  logic [vsfts_pkg::TIME_W-1:0]        time_now,
    input  logic [vsfts_pkg::TIME_W-1:0]        predicted_vsync,
    input  logic [vsfts_pkg::TIME_W-1:0]        last_presented,
    input  vsfts_pkg::dp_cmd_t                  cmd,
    output vsfts_pkg::dp_status_t               sts,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [vsfts_pkg::WIDE_W-1:0] start_time,
    output logic [vsfts_pkg::TIME_W-1:0]        target_time
);

    localparam int TW = vsfts_pkg::TIME_W;
    localparam int WW = vsfts_pkg::WIDE_W;
    localparam int CW = vsfts_pkg::CFG_W;

    logic [CW-1:0] frame_interval_reg, frame_interval_next;
    logic [CW-1:0] start_offset_reg, start_offset_next;
    logic [TW-1:0] last_target_reg, last_target_next;
    logic          out_valid_reg, out_valid_next;

    logic [vsfts_pkg::CMD_W-1:0] cmd_reg;
    logic [TW-1:0] now_reg, pred_reg, last_reg;
    logic [WW-1:0] next_reg, cand_reg;
    logic [WW-1:0] start_reg;
    logic [TW-1:0] target_reg;

    logic [CW-1:0] ivl, off, rem, ivl_gap;
    logic          rem_nz, div_busy;
    logic [WW-1:0] need1, need2, dividend, up1, up2, step_up, target_wide;
    logic [TW-1:0] target_sat;

    // Zero interval counts as one ns, zero offset as one full interval.
    assign ivl = (frame_interval_reg == '0) ? CW'(1) : frame_interval_reg;
    assign off = (start_offset_reg == '0) ? ivl : start_offset_reg;

    assign need1 = WW'(now_reg) + WW'(off);
    assign need2 = WW'(last_target_reg) + WW'(ivl >> 1);

    // Round a need up to the next vsync on the grid: need - rem + ivl when rem != 0.
    assign rem_nz  = (rem != '0);
    assign ivl_gap = ivl - rem;
    assign step_up = rem_nz ? WW'(ivl_gap) : '0;
    assign up1     = need1 + step_up;
    assign up2     = need2 + step_up;

    always_comb
    begin
        unique case (cmd.div_src)
            vsfts_pkg::DIV_ELAPSED: dividend = WW'(now_reg - last_reg);
            vsfts_pkg::DIV_NEED1:   dividend = need1 - next_reg;
            vsfts_pkg::DIV_NEED2:   dividend = need2 - next_reg;
            default:                dividend = '0;
        endcase
    end

    vsfts_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (ivl),
        .busy     (div_busy),
        .rem      (rem)
    );

    assign target_wide = cand_reg;
    assign target_sat  = target_wide[WW-1] ? vsfts_pkg::TIME_MAX : target_wide[TW-1:0];

    assign sts.div_busy      = div_busy;
    assign sts.pred_gt_now   = (pred_reg > now_reg);
    assign sts.last_gt_now   = (last_reg > now_reg);
    assign sts.next_ge_need1 = (next_reg >= need1);
    assign sts.next_ge_need2 = (next_reg >= need2);
    assign sts.secondary     = (cmd_reg == vsfts_pkg::CMD_SECONDARY);
    assign sts.out_free      = !out_valid_reg || !out_stall;

    always_comb
    begin
        frame_interval_next = frame_interval_reg;
        start_offset_next   = start_offset_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                vsfts_pkg::CFG_FRAME_INTERVAL: frame_interval_next = cfg_data;
                vsfts_pkg::CFG_START_OFFSET:   start_offset_next   = cfg_data;
                default:                       ;
            endcase
        end

        last_target_next = last_target_reg;
        if (cmd.out_load && (cmd_reg == vsfts_pkg::CMD_PRIMARY))
        begin
            last_target_next = target_sat;
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_interval_reg <= vsfts_pkg::FRAME_INTERVAL_RESET;
            start_offset_reg   <= vsfts_pkg::START_OFFSET_RESET;
            last_target_reg    <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            frame_interval_reg <= frame_interval_next;
            start_offset_reg   <= start_offset_next;
            last_target_reg    <= last_target_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg  <= command;
            now_reg  <= time_now;
            pred_reg <= predicted_vsync;
            last_reg <= last_presented;
        end
        if (cmd.next_load)
        begin
            unique case (cmd.next_sel)
                vsfts_pkg::NEXT_PRED:    next_reg <= WW'(pred_reg);
                vsfts_pkg::NEXT_NOW_IVL: next_reg <= WW'(now_reg) + WW'(ivl);
                vsfts_pkg::NEXT_SNAP:    next_reg <= WW'(now_reg) + WW'(ivl_gap);
                default:                 next_reg <= next_reg;
            endcase
        end
        if (cmd.cand_load)
        begin
            unique case (cmd.cand_sel)
                vsfts_pkg::CAND_NEXT: cand_reg <= next_reg;
                vsfts_pkg::CAND_UP1:  cand_reg <= up1;
                vsfts_pkg::CAND_MAX2: cand_reg <= (up2 > cand_reg) ? up2 : cand_reg;
                default:              cand_reg <= cand_reg;
            endcase
        end
        if (cmd.out_load)
        begin
            target_reg <= target_sat;
            start_reg  <= WW'(target_sat) - WW'(off);
        end
    end

    assign out_valid   = out_valid_reg;
    assign target_time = target_reg;
    assign start_time  = start_reg;

endmodule

>>> rtl/vsfts_ctrl.sv
module vsfts_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  vsfts_pkg::dp_status_t sts,
    output vsfts_pkg::dp_cmd_t    cmd
);

    vsfts_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vsfts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            vsfts_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = vsfts_pkg::S_SNAP;
                end
            end
            vsfts_pkg::S_SNAP:
            begin
                priority if (sts.pred_gt_now)
                begin
                    cmd.next_load = 1'b1;
                    cmd.next_sel  = vsfts_pkg::NEXT_PRED;
                    state_next    = vsfts_pkg::S_NEED1;
                end
                else if (sts.last_gt_now)
                begin
                    cmd.next_load = 1'b1;
                    cmd.next_sel  = vsfts_pkg::NEXT_NOW_IVL;
                    state_next    = vsfts_pkg::S_NEED1;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = vsfts_pkg::DIV_ELAPSED;
                    state_next    = vsfts_pkg::S_WAIT0;
                end
            end
            vsfts_pkg::S_WAIT0:
            begin
                if (!sts.div_busy)
                begin
                    cmd.next_load = 1'b1;
                    cmd.next_sel  = vsfts_pkg::NEXT_SNAP;
                    state_next    = vsfts_pkg::S_NEED1;
                end
            end
            vsfts_pkg::S_NEED1:
            begin
                if (sts.next_ge_need1)
                begin
                    cmd.cand_load = 1'b1;
                    cmd.cand_sel  = vsfts_pkg::CAND_NEXT;
                    state_next    = vsfts_pkg::S_NEED2;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = vsfts_pkg::DIV_NEED1;
                    state_next    = vsfts_pkg::S_WAIT1;
                end
            end
            vsfts_pkg::S_WAIT1:
            begin
                if (!sts.div_busy)
                begin
                    cmd.cand_load = 1'b1;
                    cmd.cand_sel  = vsfts_pkg::CAND_UP1;
                    state_next    = vsfts_pkg::S_NEED2;
                end
            end
            vsfts_pkg::S_NEED2:
            begin
                // Skip the last-target rule for a secondary request.
                if (sts.secondary || sts.next_ge_need2)
                begin
                    state_next = vsfts_pkg::S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = vsfts_pkg::DIV_NEED2;
                    state_next    = vsfts_pkg::S_WAIT2;
                end
            end
            vsfts_pkg::S_WAIT2:
            begin
                if (!sts.div_busy)
                begin
                    cmd.cand_load = 1'b1;
                    cmd.cand_sel  = vsfts_pkg::CAND_MAX2;
                    state_next    = vsfts_pkg::S_DONE;
                end
            end
            vsfts_pkg::S_DONE:
            begin
                // Hold until the output register can take the result.
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = vsfts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = vsfts_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/vsync_frame_target_scheduler.sv
// Vsync frame target scheduler. Each request carries the current time, the
// predicted next vsync and the last actual presentation (ns, 63 bits); the
// block answers with one result: the vsync the frame targets and the time at
// which frame work should begin (target minus the start offset, where an
// offset of zero means one full interval). A prediction that is not after now
// is replaced by now plus one interval if the last presentation is after now,
// else by a snap to the presentation phase. The target is then pushed forward
// by whole intervals until the start is not before now and, for a primary
// request, the target lies at least half an interval past the last targeted
// vsync; a primary request stores its target, a secondary one stores nothing.
// A target beyond 2^63-1 saturates there. Rate: one request at a time; the
// result waits in S_DONE while the previous result sits stalled in the output
// register. A shared restoring remainder unit does the work, up to three times
// a request (phase snap, start constraint, last-target constraint), plus
// controller steps. A new request is taken while the previous result still
// waits in the output register. Program frame_interval and start_offset while
// the block is idle.
`include "vsync_frame_target_scheduler_assert.svh"

module vsync_frame_target_scheduler
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [vsfts_pkg::IDX_W-1:0]         cfg_index,
    input  logic [vsfts_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [vsfts_pkg::CMD_W-1:0]         command,
    input  logic [vsfts_pkg::TIME_W-1:0]        time_now,
    input  logic [vsfts_pkg::TIME_W-1:0]        predicted_vsync,
    input  logic [vsfts_pkg::TIME_W-1:0]        last_presented,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [vsfts_pkg::WIDE_W-1:0] start_time,
    output logic [vsfts_pkg::TIME_W-1:0]        target_time
);

    vsfts_pkg::dp_cmd_t    cmd;
    vsfts_pkg::dp_status_t sts;

    // Sequence the request: snap, start constraint, last-target constraint.
    vsfts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold registers, request fields, the remainder unit and the result.
    vsfts_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .command         (command),
        .time_now        (time_now),
        .predicted_vsync (predicted_vsync),
        .last_presented  (last_presented),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .start_time      (start_time),
        .target_time     (target_time)
    );

    // Never restart the remainder unit while it still runs.
    `VFTS_ASSERT_SAME(a_div_start_idle, clk, rst_n, cmd.div_start, !sts.div_busy)

    // Never overwrite a result that is still waiting to be taken.
    `VFTS_ASSERT_SAME(a_out_load_free, clk, rst_n, cmd.out_load, !out_valid || !out_stall)

    // Stall the input in the cycle after a request is taken.
    `VFTS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule
